/* rtl/stream_find_replace_defines.svh */
// Assertion macros shared by the stream find/replace RTL.
// Included by the top level only; no other dependencies.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sfr_pkg.sv */
// Types, codes and helpers for the stream find/replace block.
// No dependencies; imported by sfr_match and stream_find_replace.
package sfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int STR_MAX = 16;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_REPL = 3'b100
    } state_t;

    typedef enum logic [2:0]
    {
        REG_PAT_LEN = 3'd0,
        REG_PAT_LO  = 3'd1,
        REG_PAT_HI  = 3'd2,
        REG_REP_LEN = 3'd3,
        REG_REP_LO  = 3'd4,
        REG_REP_HI  = 3'd5
    } reg_index_t;

    typedef struct packed
    {
        logic full;
        logic partial;
    } match_t;

    function automatic logic [BYTE_W-1:0] byte_at(
        input logic [STR_MAX*BYTE_W-1:0] vec,
        input logic [3:0]                idx
    );
        byte_at = vec[BYTE_W*idx +: BYTE_W];
    endfunction

endpackage

/* rtl/stream_find_replace.sv */
// Top level of the stream find/replace block: config registers, held-byte
// shift line, sequencer and output register. Depends on sfr_pkg, sfr_match
// and stream_find_replace_defines.svh.
//
// Text bytes enter one per beat; every occurrence of the pattern is replaced.
// s_tready is high only while the sequencer is idle. After a byte is taken,
// the sequencer steps through each candidate match start, sending the byte
// released by a mismatch at that step, and then through each replacement
// byte. A byte held as a partial match returns it to idle without sending;
// a full match with an empty replacement sends nothing. A stalled master
// side holds the sequencer. A bare end marker beat (tuser low) ends the
// text when no byte is left to send.
`include "stream_find_replace_defines.svh"

module stream_find_replace #(
    parameter int MAX_PATTERN     = 16,
    parameter int MAX_REPLACEMENT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] result_byte
    output logic        m_tuser,   // byte_present
    output logic        m_tlast,   // final_result
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_data
);
    import sfr_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN+1);
    localparam int RW = (MAX_REPLACEMENT < 1) ? 1 : $clog2(MAX_REPLACEMENT+1);

    logic [4:0]  pat_len_reg;
    logic [63:0] pat_lo_reg;
    logic [63:0] pat_hi_reg;
    logic [4:0]  rep_len_reg;
    logic [63:0] rep_lo_reg;
    logic [63:0] rep_hi_reg;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [RW-1:0]              rep_idx_reg, rep_idx_next;
    logic                       last_reg;
    logic [MAX_PATTERN-1:0][7:0] held_reg;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_present_reg;
    logic       out_final_reg;

    logic [CW-1:0] p_sat;
    logic [RW-1:0] r_sat;
    match_t        cmp;
    logic          accept;
    logic          can_emit;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_present;
    logic          emit_final;
    logic          shift;
    logic          cfg_hit;

    assign p_sat = (pat_len_reg > 5'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : pat_len_reg[CW-1:0];
    assign r_sat = (rep_len_reg > 5'(MAX_REPLACEMENT)) ? RW'(MAX_REPLACEMENT)
                                                       : rep_len_reg[RW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_emit = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_present_reg;
    assign m_tlast  = out_final_reg;

    sfr_match #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_match (
        .held    (held_reg),
        .count   (count_reg),
        .plen    (p_sat),
        .pattern ({pat_hi_reg, pat_lo_reg}),
        .result  (cmp)
    );

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PAT_LEN, REG_PAT_LO, REG_PAT_HI,
                REG_REP_LEN, REG_REP_LO, REG_REP_HI: cfg_hit = 1'b1;
                default:                             cfg_hit = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rep_idx_next = rep_idx_reg;
        emit         = 1'b0;
        emit_byte    = held_reg[0];
        emit_present = 1'b1;
        emit_final   = 1'b0;
        shift        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (count_reg == '0)
                begin
                    if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (can_emit)
                    begin
                        emit         = 1'b1;
                        emit_byte    = '0;
                        emit_present = 1'b0;
                        emit_final   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (cmp.full)
                begin
                    count_next   = '0;
                    rep_idx_next = '0;
                    state_next   = (r_sat == '0) ? ST_SCAN : ST_REPL;
                end
                else if (cmp.partial && !last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_final = last_reg && (count_reg == CW'(1));
                    shift      = 1'b1;
                    count_next = count_reg - CW'(1);
                    state_next = emit_final ? ST_IDLE : ST_SCAN;
                end
            end
            ST_REPL:
            begin
                if (can_emit)
                begin
                    emit         = 1'b1;
                    emit_byte    = byte_at({rep_hi_reg, rep_lo_reg}, 4'(rep_idx_reg));
                    emit_final   = last_reg && (rep_idx_reg == r_sat - RW'(1));
                    rep_idx_next = rep_idx_reg + RW'(1);
                    if (rep_idx_reg == r_sat - RW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_hit)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= '0;
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            rep_len_reg <= '0;
            rep_lo_reg  <= '0;
            rep_hi_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PAT_LEN: pat_len_reg <= cfg_data[4:0];
                REG_PAT_LO:  pat_lo_reg  <= cfg_data;
                REG_PAT_HI:  pat_hi_reg  <= cfg_data;
                REG_REP_LEN: rep_len_reg <= cfg_data[4:0];
                REG_REP_LO:  rep_lo_reg  <= cfg_data;
                REG_REP_HI:  rep_hi_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rep_idx_reg   <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rep_idx_reg <= rep_idx_next;
            if (accept)
            begin
                last_reg <= s_tlast;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg    <= emit_byte;
            out_present_reg <= emit_present;
            out_final_reg   <= emit_final;
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (accept && (count_reg == CW'(i)))
            begin
                held_reg[i] <= s_tdata;
            end
            else if (shift && (i < MAX_PATTERN - 1))
            begin
                held_reg[i] <= held_reg[(i < MAX_PATTERN - 1) ? i + 1 : i];
            end
        end
    end

    `SFR_ASSERT_NOW(a_idle_hold_short, state_reg == ST_IDLE, (count_reg == '0) || (count_reg < p_sat), "held run not shorter than pattern while idle")
    `SFR_ASSERT_NOW(a_repl_in_range, state_reg == ST_REPL, rep_idx_reg < r_sat, "replacement index out of range")
    `SFR_ASSERT_NOW(a_bare_is_final, m_tvalid && !m_tuser, m_tlast, "bare end marker beat without final flag")
    `SFR_ASSERT_NEXT(a_accept_scans, accept && !cfg_we, state_reg == ST_SCAN, "accepted byte not scanned")

endmodule

/* rtl/sfr_match.sv */
// Parallel byte compare of the held run against the pattern prefix.
// Depends on sfr_pkg.
module sfr_match #(
    parameter int MAX_PATTERN = 16
) (
    input  logic [MAX_PATTERN-1:0][7:0]           held,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]      count,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]      plen,
    input  logic [sfr_pkg::STR_MAX*8-1:0]         pattern,
    output sfr_pkg::match_t                       result
);
    import sfr_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN+1);

    logic all_eq;

    always_comb
    begin
        all_eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CW'(i) < count) && (CW'(i) < plen) &&
                (held[i] != byte_at(pattern, 4'(i))))
            begin
                all_eq = 1'b0;
            end
        end
        result.full    = (plen != '0) && (count >= plen) && all_eq;
        result.partial = (plen != '0) && (count <  plen) && all_eq;
    end

endmodule
